// ===== rtl/core/lppd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lppd_pkg;

    // Header length in bytes; the first two bytes carry the packet size
    localparam int LPPD_HEADER_BYTES = 4;

    // Reset value of the maximum packet size register
    localparam logic [15:0] LPPD_MAX_BYTES_RST = 16'd4096;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_UNDER = 2'd1,
        FAULT_OVER  = 2'd2
    } t_fault;

    // One result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       first_of_packet;
        logic       last_of_packet;
        t_fault     fault_code;
        logic       halted;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/lppd_pipe_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lppd_pipe_reg #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);

    logic             r_valid;
    logic [WIDTH-1:0] r_data;

    // Take a new transaction when empty or when the held one leaves
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/lppd_frame_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lppd_frame_ctrl #(
    parameter int HEADER_BYTES = lppd_pkg::LPPD_HEADER_BYTES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [15:0]       i_cfg_wr_data,
    input  wire logic              i_item_valid,
    output logic                   o_item_ready,
    input  wire logic [7:0]        i_item_byte,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output lppd_pkg::t_result      o_res
);

    import lppd_pkg::*;

    localparam logic [15:0] LAST_HDR_POS = 16'(HEADER_BYTES - 1);
    localparam logic [15:0] HDR_LEN      = 16'(HEADER_BYTES);

    logic [15:0] r_max_bytes;
    logic [15:0] r_byte_pos;
    logic [7:0]  r_size_low;
    logic [15:0] r_pkt_len;
    logic        r_stopped;

    logic [15:0] n_byte_pos;
    logic [15:0] w_len;
    logic [16:0] w_pos_inc;
    logic        w_fire;
    t_fault      w_fault;
    logic        w_last;

    // Pass the handshake straight through to the result register
    assign o_res_valid  = i_item_valid;
    assign o_item_ready = i_res_ready;
    assign w_fire       = i_item_valid && i_res_ready;

    // Size is complete once the second header byte is here
    assign w_len     = (r_byte_pos == 16'd1) ? {i_item_byte, r_size_low} : r_pkt_len;
    assign w_pos_inc = {1'b0, r_byte_pos} + 17'd1;

    // Check the size on the last header byte, underflow first
    always_comb begin
        w_fault = FAULT_NONE;
        if (!r_stopped && r_byte_pos == LAST_HDR_POS) begin
            if (w_len < HDR_LEN) begin
                w_fault = FAULT_UNDER;
            end else if (w_len > r_max_bytes) begin
                w_fault = FAULT_OVER;
            end
        end
    end

    assign w_last = !r_stopped && (w_fault == FAULT_NONE) && (r_byte_pos >= LAST_HDR_POS)
                    && (w_pos_inc >= {1'b0, w_len});

    // Advance the byte position, wrap at packet end
    always_comb begin
        if (w_last) begin
            n_byte_pos = '0;
        end else begin
            n_byte_pos = w_pos_inc[15:0];
        end
    end

    // Build the result transaction
    always_comb begin
        o_res.out_byte = i_item_byte;
        if (r_stopped) begin
            o_res.byte_valid      = 1'b0;
            o_res.first_of_packet = 1'b0;
            o_res.last_of_packet  = 1'b0;
            o_res.fault_code      = FAULT_NONE;
            o_res.halted          = 1'b1;
        end else begin
            o_res.byte_valid      = (w_fault == FAULT_NONE);
            o_res.first_of_packet = (r_byte_pos == 16'd0);
            o_res.last_of_packet  = w_last;
            o_res.fault_code      = w_fault;
            o_res.halted          = (w_fault != FAULT_NONE);
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= LPPD_MAX_BYTES_RST;
        end else if (i_cfg_wr_en) begin
            r_max_bytes <= i_cfg_wr_data;
        end
    end

    // Update framing state per transaction; hold while halted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= '0;
            r_size_low <= '0;
            r_pkt_len  <= '0;
            r_stopped  <= 1'b0;
        end else if (w_fire && !r_stopped) begin
            if (r_byte_pos == 16'd0) begin
                r_size_low <= i_item_byte;
            end
            if (r_byte_pos == 16'd1) begin
                r_pkt_len <= w_len;
            end
            if (w_fault != FAULT_NONE) begin
                r_stopped <= 1'b1;
            end else begin
                r_byte_pos <= n_byte_pos;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/length_prefixed_packet_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Path: an accepted input transaction is held in the input register, passes through the
// combinational framing logic, and is taken into the result register that drives the outputs.
// Throughput: one byte per cycle, set by the input and result registers around the
// combinational framing logic; both sides may stall independently.
// Reset (synchronous, active low): clears position, size and halt state, and sets
// the maximum packet size to 4096; no clearing pass, ready right after reset.
module length_prefixed_packet_deframer #(
    parameter int HEADER_BYTES = lppd_pkg::LPPD_HEADER_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic             o_first_of_packet,
    output logic             o_last_of_packet,
    output logic [1:0]       o_fault_code,
    output logic             o_halted
);

    import lppd_pkg::*;

    localparam int RES_W = $bits(t_result);

    logic             w_in_ready;
    logic             w_item_valid;
    logic             w_item_ready;
    logic [7:0]       w_item_byte;
    logic             w_res_valid;
    logic             w_res_ready;
    t_result          w_res;
    logic [RES_W-1:0] w_out_bits;
    t_result          w_out;

    // Input register
    lppd_pipe_reg #(
        .WIDTH (8)
    ) u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (w_in_ready),
        .i_data  (i_data_byte),
        .o_valid (w_item_valid),
        .i_ready (w_item_ready),
        .o_data  (w_item_byte)
    );

    // Framing logic and state
    lppd_frame_ctrl #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item_valid  (w_item_valid),
        .o_item_ready  (w_item_ready),
        .i_item_byte   (w_item_byte),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res         (w_res)
    );

    // Result register
    lppd_pipe_reg #(
        .WIDTH (RES_W)
    ) u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .o_ready (w_res_ready),
        .i_data  (w_res),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_data  (w_out_bits)
    );

    assign o_stall = !w_in_ready;

    // Unpack the result transaction onto the ports
    assign w_out             = t_result'(w_out_bits);
    assign o_out_byte        = w_out.out_byte;
    assign o_byte_valid      = w_out.byte_valid;
    assign o_first_of_packet = w_out.first_of_packet;
    assign o_last_of_packet  = w_out.last_of_packet;
    assign o_fault_code      = w_out.fault_code;
    assign o_halted          = w_out.halted;

endmodule

`default_nettype wire

// ===== verif/tb_length_prefixed_packet_deframer.sv =====
`timescale 1ns / 1ps

module tb_length_prefixed_packet_deframer;
    import lppd_pkg::*;

    localparam int HDR         = LPPD_HEADER_BYTES;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_first_of_packet;
    logic        o_last_of_packet;
    logic [1:0]  o_fault_code;
    logic        o_halted;

    // Deframer prediction state
    logic [15:0] max_bytes_q;
    logic [15:0] pos_q;
    logic [7:0]  size_lo_q;
    logic [15:0] len_q;
    logic        halt_q;

    t_result     expected_bytes[$];
    int          fail_count    = 0;
    int          cycle_count   = 0;
    int          results_seen  = 0;
    int          bytes_sent    = 0;
    int          packets_sent  = 0;
    int          burst_left    = 0;
    int          stall_mode    = 0;
    int          stall_left    = 0;
    int          stall_phase   = 0;
    string       fault_kind    = "none";

    length_prefixed_packet_deframer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_byte       (o_out_byte),
        .o_byte_valid     (o_byte_valid),
        .o_first_of_packet(o_first_of_packet),
        .o_last_of_packet (o_last_of_packet),
        .o_fault_code     (o_fault_code),
        .o_halted         (o_halted)
    );

    always #5 i_clk = ~i_clk;

    // Predict the result of one byte and advance the framing state
    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result r;
        int unsigned pos;
        r = '0;
        r.out_byte = b;
        r.fault_code = FAULT_NONE;
        if (halt_q) begin
            r.halted = 1'b1;
            return r;
        end
        pos = pos_q;
        r.byte_valid = 1'b1;
        if (pos == 0) begin
            r.first_of_packet = 1'b1;
            size_lo_q = b;
        end
        if (pos == 1)
            len_q = {b, size_lo_q};
        if (pos == HDR - 1) begin
            // Underflow takes priority over overflow
            if (len_q < HDR)
                r.fault_code = FAULT_UNDER;
            else if (len_q > max_bytes_q)
                r.fault_code = FAULT_OVER;
        end
        if (r.fault_code != FAULT_NONE) begin
            halt_q = 1'b1;
            r.byte_valid = 1'b0;
        end else if (pos >= HDR - 1 && pos + 1 >= len_q) begin
            r.last_of_packet = 1'b1;
            pos_q = '0;
        end else begin
            pos_q = pos_q + 16'd1;
        end
        r.halted = halt_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 results_seen, what, got, want);
    endtask

    // Send one byte: gap between bursts, then hold until the transaction is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_bytes.insert(expected_bytes.size(), deframe_byte(b));
        bytes_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // Send the header of a packet declaring the given size
    task automatic send_header(input logic [15:0] size);
        send_byte(size[7:0]);
        send_byte(size[15:8]);
        repeat (HDR - 2) send_byte(8'($urandom));
    endtask

    task automatic send_packet(input logic [15:0] size);
        send_header(size);
        repeat (int'(size) - HDR) send_byte(8'($urandom));
        packets_sent++;
    endtask

    // Drain all results, then write the size limit while the block is idle
    task automatic write_max_bytes(input logic [15:0] v);
        i_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        max_bytes_q = v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 16'($urandom);
        @(negedge i_clk);
    endtask

    // Size boundaries with the reset limit and with small limits
    task automatic test_directed_sizes();
        send_packet(16'(HDR));
        send_packet(16'(HDR + 2));
        write_max_bytes(16'd7);
        send_packet(16'd7);
        write_max_bytes(16'(HDR));
        send_packet(16'(HDR));
    endtask

    // Well-formed packets with random content under a series of limits
    task automatic test_random_packets();
        logic [15:0] limits[6];
        int          cap;
        int          phase_end;
        limits[0] = 16'hFFFF;
        limits[1] = LPPD_MAX_BYTES_RST;
        limits[2] = 16'($urandom_range(HDR, 600));
        limits[3] = 16'(HDR);
        limits[4] = 16'($urandom_range(HDR, 65535));
        limits[5] = 16'(HDR + 1);
        foreach (limits[k]) begin
            write_max_bytes(limits[k]);
            phase_end = bytes_sent + 290;
            while (bytes_sent < phase_end) begin
                if ($urandom_range(0, 15) == 0)
                    cap = (max_bytes_q < 400) ? int'(max_bytes_q) : 400;
                else
                    cap = (max_bytes_q < 40) ? int'(max_bytes_q) : 40;
                send_packet(16'($urandom_range(HDR, cap)));
            end
        end
    endtask

    // Raise one fault, then feed bytes through the halted block
    task automatic test_fault_and_halt();
        logic [15:0] size;
        case ($urandom_range(0, 2))
            0: begin
                fault_kind = "underflow";
                // Sometimes with a limit below the header so both checks could trip
                if ($urandom_range(0, 1) == 0)
                    write_max_bytes(16'($urandom_range(0, HDR - 1)));
                size = 16'($urandom_range(0, HDR - 1));
            end
            1: begin
                fault_kind = "overflow";
                write_max_bytes(16'($urandom_range(HDR, 1000)));
                size = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                     : 16'($urandom_range(int'(max_bytes_q) + 1, 65535));
            end
            default: begin
                fault_kind = "overflow, limit below header";
                write_max_bytes(16'($urandom_range(0, HDR - 1)));
                size = 16'($urandom_range(HDR, 65535));
            end
        endcase
        // Lead with a good packet so the fault lands mid-stream
        if (max_bytes_q >= HDR)
            send_packet(16'(HDR));
        send_header(size);
        repeat (30) send_byte(8'($urandom));
        write_max_bytes(16'hFFFF);
        repeat (30) send_byte(8'($urandom));
    endtask

    // Receiver stall pattern: switch among modes every so often
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 80);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= ($urandom_range(0, 9) < 7);
            default: i_stall <= stall_phase[0];
        endcase
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("result with nothing outstanding", 1, 0);
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_byte !== want.out_byte)
                    report_mismatch("out_byte", o_out_byte, want.out_byte);
                if (o_byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", o_byte_valid, want.byte_valid);
                if (o_first_of_packet !== want.first_of_packet)
                    report_mismatch("first_of_packet", o_first_of_packet,
                                    want.first_of_packet);
                if (o_last_of_packet !== want.last_of_packet)
                    report_mismatch("last_of_packet", o_last_of_packet,
                                    want.last_of_packet);
                if (o_fault_code !== want.fault_code)
                    report_mismatch("fault_code", o_fault_code, want.fault_code);
                if (o_halted !== want.halted)
                    report_mismatch("halted", o_halted, want.halted);
            end
            results_seen++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_bytes.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_data_byte   = '0;
        i_stall       = 1'b0;
        max_bytes_q   = LPPD_MAX_BYTES_RST;
        pos_q         = '0;
        size_lo_q     = '0;
        len_q         = '0;
        halt_q        = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_sizes();
        test_random_packets();
        test_fault_and_halt();

        // Drain and let the pipeline settle
        i_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("sent %0d bytes in %0d packets, checked %0d results",
                 bytes_sent, packets_sent, results_seen);
        $display("closing fault: %s, mismatches: %0d", fault_kind, fail_count);
        if (fail_count == 0 && expected_bytes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
